// ----- src/scrp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scrp_pkg: shared types and helpers for the submission/completion ring pair
// Ring depth, pointer and count widths, item kinds, pointer arithmetic.
// ----------------------------------------------------------------------------
package scrp_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PTR_W   = $clog2(2 * DEPTH);
  localparam int CNT_W   = 5;
  localparam int OP_W    = 8;
  localparam int TAG_W   = 64;
  localparam int KIND_W  = 2;

  localparam logic [OP_W-1:0] OP_LAST_KNOWN = OP_W'(2);

  typedef enum logic [KIND_W-1:0] {
    KIND_SUBMIT = 2'd0,
    KIND_POLL   = 2'd1,
    KIND_GET    = 2'd2
  } kind_t;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    ptr_t sub_rd;
    ptr_t sub_wr;
    ptr_t done_rd;
    ptr_t done_wr;
  } ptrs_t;

  typedef struct packed {
    ptr_t sub_occ;
    ptr_t done_occ;
    logic sub_empty;
    logic sub_full;
    logic done_empty;
    logic done_full;
  } occ_t;

  function automatic ptr_t ptr_inc(input ptr_t p);
    return (p == ptr_t'(2 * DEPTH - 1)) ? '0 : ptr_t'(p + ptr_t'(1));
  endfunction

  function automatic idx_t slot(input ptr_t p);
    logic [PTR_W-1:0] s;
    s = (p >= ptr_t'(DEPTH)) ? ptr_t'(p - ptr_t'(DEPTH)) : p;
    return s[IDX_W-1:0];
  endfunction

  function automatic ptr_t occupancy(input ptr_t wr, input ptr_t rd);
    return (wr >= rd) ? ptr_t'(wr - rd) : ptr_t'(wr + ptr_t'(2 * DEPTH) - rd);
  endfunction

  function automatic logic [CNT_W-1:0] count5(input ptr_t occ);
    logic [31:0] wide;
    wide = 32'(occ);
    return wide[CNT_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- src/scrp_occ.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scrp_occ: ring occupancy and flags
// Derives occupancy, empty and full for both rings from their pointers.
// ----------------------------------------------------------------------------
module scrp_occ
  import scrp_pkg::*;
(
  input  var ptrs_t ptrs,
  output occ_t      occ
);

  always_comb begin
    occ.sub_occ    = occupancy(ptrs.sub_wr, ptrs.sub_rd);
    occ.done_occ   = occupancy(ptrs.done_wr, ptrs.done_rd);
    occ.sub_empty  = (ptrs.sub_wr == ptrs.sub_rd);
    occ.done_empty = (ptrs.done_wr == ptrs.done_rd);
    occ.sub_full   = (occ.sub_occ >= ptr_t'(DEPTH));
    occ.done_full  = (occ.done_occ >= ptr_t'(DEPTH));
  end

endmodule
`default_nettype wire

// ----- src/submission_completion_ring_pair.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// submission_completion_ring_pair: submission and completion rings, 16 deep
// Input words (kind, opcode, tag) arrive on in_valid/in_stall; one result
// word (ok, done_tag, status, sub_count, done_count) leaves per input word on
// out_valid/out_stall. cfg_we writes enable from cfg_wdata at any idle time.
// Submit, get and a poll while disabled: once the input word is taken, the
// sequencer enters ST_RESULT and loads the result register when the output
// register is free. The rings sit in single-port arrays, one access per cycle
// each. Poll: the drain sequencer moves one entry at a time (ST_DRAIN reads a
// submission slot, then ST_DRAIN_WR writes a completion slot) until the
// submission ring is empty or the completion ring is full, then loads its
// result likewise. in_stall is high while a word is worked, so a new word
// is taken only after the last one has loaded its result.
// Reset (rst, synchronous) empties both rings, clears enable and drops any
// pending result. While the receiver stalls, the result word holds in its
// register; a new input word is still taken, and its result waits in the
// sequencer until the register frees.
// ----------------------------------------------------------------------------
module submission_completion_ring_pair
  import scrp_pkg::*;
(
  input  var logic                clk,
  input  var logic                rst,
  input  var logic                cfg_we,
  input  var logic                cfg_wdata,
  input  var logic                in_valid,
  output logic                    in_stall,
  input  var logic [KIND_W-1:0]   kind,
  input  var logic [OP_W-1:0]     opcode,
  input  var logic [TAG_W-1:0]    tag,
  output logic                    out_valid,
  input  var logic                out_stall,
  output logic                    ok,
  output logic [TAG_W-1:0]        done_tag,
  output logic signed             status,
  output logic [CNT_W-1:0]        sub_count,
  output logic [CNT_W-1:0]        done_count
);

  typedef enum logic [3:0] {
    ST_IDLE     = 4'b0001,
    ST_DRAIN    = 4'b0010,
    ST_DRAIN_WR = 4'b0100,
    ST_RESULT   = 4'b1000
  } state_t;

  state_t state;
  logic   enable;
  ptrs_t  ptrs;
  occ_t   occ;

  logic [OP_W-1:0]  sub_opcodes [DEPTH];
  logic [TAG_W-1:0] sub_tags    [DEPTH];
  logic [TAG_W-1:0] done_tags   [DEPTH];
  logic             done_fail   [DEPTH];

  logic [OP_W-1:0]  sub_rd_op;
  logic [TAG_W-1:0] sub_rd_tag;
  logic [TAG_W-1:0] done_rd_tag;
  logic             done_rd_fail;

  logic res_ok;
  logic res_get;

  logic in_accept;
  logic sub_we;
  logic sub_re;
  logic done_we;
  logic done_re;
  logic out_free;

  scrp_occ u_occ (
    .ptrs (ptrs),
    .occ  (occ)
  );

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign sub_we    = in_accept && (kind == KIND_SUBMIT) && enable && !occ.sub_full;
  assign done_re   = in_accept && (kind == KIND_GET) && !occ.done_empty;
  assign sub_re    = (state == ST_DRAIN) && !occ.sub_empty;
  assign done_we   = (state == ST_DRAIN_WR) && !occ.done_full;
  assign out_free  = !out_valid || !out_stall;

  // ring storage
  always_ff @(posedge clk) begin
    if (sub_we) begin
      sub_opcodes[slot(ptrs.sub_wr)] <= opcode;
      sub_tags[slot(ptrs.sub_wr)]    <= tag;
    end
    if (sub_re) begin
      sub_rd_op  <= sub_opcodes[slot(ptrs.sub_rd)];
      sub_rd_tag <= sub_tags[slot(ptrs.sub_rd)];
    end
  end

  always_ff @(posedge clk) begin
    if (done_we) begin
      done_tags[slot(ptrs.done_wr)] <= sub_rd_tag;
      done_fail[slot(ptrs.done_wr)] <= (sub_rd_op > OP_LAST_KNOWN);
    end
    if (done_re) begin
      done_rd_tag  <= done_tags[slot(ptrs.done_rd)];
      done_rd_fail <= done_fail[slot(ptrs.done_rd)];
    end
  end

  // pending result of the word in work
  always_ff @(posedge clk) begin
    if (in_accept) begin
      case (kind)
        KIND_SUBMIT: begin
          res_ok  <= sub_we;
          res_get <= 1'b0;
        end
        KIND_POLL: begin
          res_ok  <= 1'b1;
          res_get <= 1'b0;
        end
        KIND_GET: begin
          res_ok  <= done_re;
          res_get <= done_re;
        end
        default: begin
          res_ok  <= 1'b0;
          res_get <= 1'b0;
        end
      endcase
    end
  end

  // sequencer and pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      enable       <= 1'b0;
      ptrs         <= '0;
    end else begin
      if (cfg_we) begin
        enable <= cfg_wdata;
      end
      if (sub_we) begin
        ptrs.sub_wr <= ptr_inc(ptrs.sub_wr);
      end
      if (sub_re) begin
        ptrs.sub_rd <= ptr_inc(ptrs.sub_rd);
      end
      if (done_we) begin
        ptrs.done_wr <= ptr_inc(ptrs.done_wr);
      end
      if (done_re) begin
        ptrs.done_rd <= ptr_inc(ptrs.done_rd);
      end
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            state <= ((kind == KIND_POLL) && enable) ? ST_DRAIN : ST_RESULT;
          end
        end
        ST_DRAIN: begin
          state <= occ.sub_empty ? ST_RESULT : ST_DRAIN_WR;
        end
        ST_DRAIN_WR: begin
          // completion ring full: drop the popped entry and stop
          state <= occ.done_full ? ST_RESULT : ST_DRAIN;
        end
        ST_RESULT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_RESULT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESULT && out_free) begin
      ok         <= res_ok;
      done_tag   <= res_get ? done_rd_tag : '0;
      status     <= res_get ? done_rd_fail : 1'b0;
      sub_count  <= count5(occ.sub_occ);
      done_count <= count5(occ.done_occ);
    end
  end

  a_sub_bound: assert property (@(posedge clk) disable iff (rst)
    occ.sub_occ <= ptr_t'(DEPTH))
    else $error("submission ring over capacity");

  a_done_bound: assert property (@(posedge clk) disable iff (rst)
    occ.done_occ <= ptr_t'(DEPTH))
    else $error("completion ring over capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> in_stall)
    else $error("input taken while previous word in work");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_RESULT))
    else $error("result word appeared outside result step");

  a_drain_write_guard: assert property (@(posedge clk) disable iff (rst)
    done_we |-> !occ.done_full && !sub_re && !done_re)
    else $error("completion write collides with other ring access");

endmodule
`default_nettype wire
